[rtl/mvre_pkg.sv]
// Shared types and constants of the matrix vector reduction engine.
// No dependencies; every other file of the block but mvre_ram imports this package.
package mvre_pkg;

  localparam int ACC_W      = 41;   // accumulator width, wraps here
  localparam int VALUE_W    = 27;   // result value field
  localparam int INDEX_W    = 10;   // result vector index field
  localparam int OUT_DATA_W = 32;   // value padded to whole bytes
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 11;
  localparam int ROWCNT_W   = 11;
  localparam int COLCNT_W   = 7;

  localparam int DIV_STEPS  = ACC_W;
  localparam int ROOT_STEPS = (ACC_W + 1) / 2;
  localparam int ROOT_TOP   = 2 * (ROOT_STEPS - 1);
  localparam int STEP_W     = 6;

  typedef enum logic [1:0] {
    MODE_SUM    = 2'd0,
    MODE_ROOT   = 2'd1,
    MODE_RMS    = 2'd2,
    MODE_CUMSUM = 2'd3
  } mode_t;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT = 4'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACCUM,
    ST_DRAIN_RD,
    ST_DRAIN_DATA,
    ST_FINISH,
    ST_RESULT
  } eng_state_t;

  typedef enum logic [1:0] {
    FS_IDLE,
    FS_DIVIDE,
    FS_ROOT
  } fin_state_t;

  typedef struct packed {
    logic start;
    logic divide;
  } fin_req_t;

endpackage

[rtl/matrix_vector_reduction_engine.sv]
// Top level of the matrix vector reduction engine: control, column store, output beat.
// Depends on mvre_pkg, mvre_ram and mvre_finish.
//
//  channel  | direction | beat contents
//  ---------+-----------+------------------------------------------------
//  s_axis   | in        | tdata: element
//  m_axis   | out       | tdata: value; tuser: vector_index; tlast: last
//  cfg      | in        | cfg_index: register number; cfg_data: value
//
// Each element passes an accept step, then one read-modify-write of the column
// accumulator RAM or the row accumulator; an element that emits a result then
// loads the output beat, plus any wait on m_axis. A new element is taken only once the last is through.
// The finishing unit holds the input for a root, and for an RMS, which runs
// 41 divide steps and then the root.
// The column drain after the last element reads each column and loads its beat,
// going through the finishing unit in root or RMS mode, plus any wait on m_axis.
// Reset (synchronous) and every write to a known register restart the matrix; the
// column store clears at once through per-column valid bits.
// A stalled output holds its beat; the next result waits in a holding register.
module matrix_vector_reduction_engine #(
  parameter int MAX_COLS     = 64,
  parameter int MAX_ROWS     = 1024,
  parameter int ELEMENT_BITS = 16,
  localparam int IN_W = ((ELEMENT_BITS + 7) / 8) * 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [IN_W-1:0]                   s_axis_tdata,   // element
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [mvre_pkg::OUT_DATA_W-1:0]   m_axis_tdata,   // value
  output logic [mvre_pkg::INDEX_W-1:0]      m_axis_tuser,   // vector_index
  output logic                              m_axis_tlast,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mvre_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mvre_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import mvre_pkg::*;

  localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CNW   = $clog2(MAX_COLS + 1);
  localparam int RNW   = $clog2(MAX_ROWS + 1);
  localparam int LEN_W = (RNW > CNW) ? RNW : CNW;

  // configuration
  mode_t                mode;
  logic                 direction;
  logic [ROWCNT_W-1:0]  row_count;
  logic [COLCNT_W-1:0]  col_count;
  logic                 cfg_fire, restart;

  // engine
  eng_state_t           state, state_next;
  logic [CW-1:0]        col_pos, drain_pos;
  logic [RW-1:0]        row_pos;
  logic [MAX_COLS-1:0]  col_valid;
  logic [ACC_W-1:0]     row_acc, addend, addend_next;
  logic                 draining;
  logic [CNW-1:0]       cols_use;
  logic [RNW-1:0]       rows_use;
  logic                 end_row, end_mat, drain_last;
  logic                 s_fire, out_free, squares;

  logic signed [ELEMENT_BITS-1:0] elem;
  logic [ELEMENT_BITS-1:0]        mag;
  logic [2*ELEMENT_BITS-1:0]      sq;

  logic [ACC_W-1:0]     ram_rdata, base, sum, drain_base;
  logic [CW-1:0]        ram_raddr;
  logic                 ram_we;

  fin_req_t             fin_req;
  logic                 fin_done;
  logic [ACC_W-1:0]     fin_root, fin_operand;
  logic [LEN_W-1:0]     fin_len;

  logic [VALUE_W-1:0]   res_val;
  logic [INDEX_W-1:0]   res_idx;
  logic                 res_last;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign restart   = cfg_fire && (cfg_index == CFG_MODE || cfg_index == CFG_DIRECTION ||
                                  cfg_index == CFG_ROW_COUNT || cfg_index == CFG_COL_COUNT);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_SUM;
      direction <= 1'b0;
      row_count <= ROWCNT_W'(1);
      col_count <= COLCNT_W'(1);
    end else if (cfg_fire) begin
      unique case (cfg_index)
        CFG_MODE:      mode      <= mode_t'(cfg_data[1:0]);
        CFG_DIRECTION: direction <= cfg_data[0];
        CFG_ROW_COUNT: row_count <= cfg_data[ROWCNT_W-1:0];
        CFG_COL_COUNT: col_count <= cfg_data[COLCNT_W-1:0];
        default: ;  // unknown register: drop the write
      endcase
    end
  end

  // Clamp the counts: zero acts as one, anything past the maximum as the maximum.
  assign rows_use = (row_count == '0) ? RNW'(1) :
                    (row_count > MAX_ROWS) ? RNW'(MAX_ROWS) : RNW'(row_count);
  assign cols_use = (col_count == '0) ? CNW'(1) :
                    (col_count > MAX_COLS) ? CNW'(MAX_COLS) : CNW'(col_count);

  assign end_row    = (CNW'(col_pos) + CNW'(1) == cols_use);
  assign end_mat    = end_row && (RNW'(row_pos) + RNW'(1) == rows_use);
  assign drain_last = (CNW'(drain_pos) + CNW'(1) == cols_use);

  // Addend: signed element, or its square in the root and RMS modes.
  assign squares     = (mode == MODE_ROOT) || (mode == MODE_RMS);
  assign elem        = signed'(s_axis_tdata[ELEMENT_BITS-1:0]);
  assign mag         = elem[ELEMENT_BITS-1] ? ELEMENT_BITS'(-elem) : ELEMENT_BITS'(elem);
  assign sq          = mag * mag;
  assign addend_next = squares ? ACC_W'(sq) : ACC_W'(elem);

  assign s_axis_tready = (state == ST_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  // Column accumulators: read in the accept cycle, written back in the cycle after.
  assign ram_raddr  = (state == ST_DRAIN_RD) ? drain_pos : col_pos;
  assign ram_we     = (state == ST_ACCUM) && !direction;
  assign base       = direction ? row_acc : (col_valid[col_pos] ? ram_rdata : '0);
  assign sum        = base + addend;
  assign drain_base = col_valid[drain_pos] ? ram_rdata : '0;

  mvre_ram #(.WIDTH(ACC_W), .DEPTH(MAX_COLS)) u_col_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (col_pos),
    .wdata (sum),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign fin_req.start  = ((state == ST_ACCUM) && direction && end_row && squares) ||
                          ((state == ST_DRAIN_DATA) && squares);
  assign fin_req.divide = (mode == MODE_RMS);
  assign fin_operand    = (state == ST_ACCUM) ? sum : drain_base;
  assign fin_len        = direction ? LEN_W'(cols_use) : LEN_W'(rows_use);

  mvre_finish #(.LEN_W(LEN_W)) u_finish (
    .clk     (clk),
    .rst     (rst),
    .req     (fin_req),
    .operand (fin_operand),
    .divisor (fin_len),
    .done    (fin_done),
    .root    (fin_root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (s_fire) state_next = ST_ACCUM;
      ST_ACCUM: begin
        if (mode == MODE_CUMSUM) begin
          state_next = ST_RESULT;
        end else if (!direction && end_mat) begin
          state_next = ST_DRAIN_RD;
        end else if (direction && end_row) begin
          state_next = squares ? ST_FINISH : ST_RESULT;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_DRAIN_RD:   state_next = ST_DRAIN_DATA;
      ST_DRAIN_DATA: state_next = squares ? ST_FINISH : ST_RESULT;
      ST_FINISH:     if (fin_done) state_next = ST_RESULT;
      ST_RESULT: begin
        if (out_free) state_next = (draining && !res_last) ? ST_DRAIN_RD : ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Positions, accumulators and valid bits.
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      col_pos   <= '0;
      row_pos   <= '0;
      row_acc   <= '0;
      col_valid <= '0;
      draining  <= 1'b0;
      drain_pos <= '0;
    end else begin
      if (state == ST_ACCUM) begin
        if (direction) begin
          row_acc <= end_row ? '0 : sum;
        end else if (end_mat && mode == MODE_CUMSUM) begin
          col_valid <= '0;
        end else begin
          col_valid[col_pos] <= 1'b1;
        end
        if (!direction && end_mat && mode != MODE_CUMSUM) begin
          draining  <= 1'b1;
          drain_pos <= '0;
        end
        if (end_row) begin
          col_pos <= '0;
          row_pos <= end_mat ? '0 : row_pos + RW'(1);
        end else begin
          col_pos <= col_pos + CW'(1);
        end
      end
      if (state == ST_RESULT && out_free && draining) begin
        if (res_last) begin
          draining  <= 1'b0;
          col_valid <= '0;
        end else begin
          drain_pos <= drain_pos + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      addend <= addend_next;
    end
    case (state)
      ST_ACCUM: begin
        res_val  <= VALUE_W'(sum);
        res_idx  <= direction ? INDEX_W'(row_pos) : INDEX_W'(col_pos);
        res_last <= end_mat;
      end
      ST_DRAIN_DATA: begin
        res_val  <= VALUE_W'(drain_base);
        res_idx  <= INDEX_W'(drain_pos);
        res_last <= drain_last;
      end
      ST_FINISH: if (fin_done) res_val <= VALUE_W'(fin_root);
      default: ;
    endcase
  end

  // Output beat register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == ST_RESULT && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_RESULT && out_free) begin
      m_axis_tdata <= OUT_DATA_W'(res_val);
      m_axis_tuser <= res_idx;
      m_axis_tlast <= res_last;
    end
  end

endmodule

[rtl/mvre_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mvre_ram #(
  parameter int WIDTH = 41,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/mvre_finish.sv]
// Iterative finishing unit: optional restoring divide, then bitwise square root.
// Depends on mvre_pkg.
module mvre_finish #(
  parameter int LEN_W = 11
) (
  input  logic                     clk,
  input  logic                     rst,
  input  mvre_pkg::fin_req_t       req,
  input  logic [mvre_pkg::ACC_W-1:0] operand,
  input  logic [LEN_W-1:0]         divisor,
  output logic                     done,
  output logic [mvre_pkg::ACC_W-1:0] root
);
  import mvre_pkg::*;

  fin_state_t        state, state_next;
  logic [STEP_W-1:0] cnt;
  logic [ACC_W-1:0]  quo;
  logic [LEN_W-1:0]  rem;
  logic [LEN_W:0]    trial;
  logic              qbit;
  logic [ACC_W-1:0]  vrem;
  logic [ACC_W-1:0]  bitv;
  logic [ACC_W-1:0]  probe;
  logic              take;
  logic              div_end, root_end;

  assign trial    = {rem, quo[ACC_W-1]};
  assign qbit     = (trial >= {1'b0, divisor});
  assign probe    = root + bitv;
  assign take     = (vrem >= probe);
  assign div_end  = (cnt == STEP_W'(DIV_STEPS - 1));
  assign root_end = (cnt == STEP_W'(ROOT_STEPS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FS_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == FS_ROOT) && root_end;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      FS_IDLE:   if (req.start) state_next = req.divide ? FS_DIVIDE : FS_ROOT;
      FS_DIVIDE: if (div_end) state_next = FS_ROOT;
      FS_ROOT:   if (root_end) state_next = FS_IDLE;
      default:   state_next = FS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      FS_IDLE: begin
        cnt  <= '0;
        quo  <= operand;
        rem  <= '0;
        vrem <= operand;
        root <= '0;
        bitv <= ACC_W'(1) << ROOT_TOP;
      end
      FS_DIVIDE: begin
        // one quotient bit a cycle
        rem <= qbit ? LEN_W'(trial - {1'b0, divisor}) : LEN_W'(trial);
        quo <= {quo[ACC_W-2:0], qbit};
        cnt <= div_end ? '0 : cnt + STEP_W'(1);
        if (div_end) begin
          vrem <= {quo[ACC_W-2:0], qbit};
        end
      end
      FS_ROOT: begin
        // one root bit a cycle
        if (take) begin
          vrem <= vrem - probe;
          root <= (root >> 1) + bitv;
        end else begin
          root <= root >> 1;
        end
        bitv <= bitv >> 2;
        cnt  <= cnt + STEP_W'(1);
      end
      default: cnt <= '0;
    endcase
  end

endmodule

[rtl/mvre_checker.sv]
// Port-level checker for the matrix vector reduction engine, bound to the top level.
// Depends on mvre_pkg and on matrix_vector_reduction_engine.
module mvre_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [mvre_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic [mvre_pkg::INDEX_W-1:0]    m_axis_tuser,
  input logic                            m_axis_tlast
);
  import mvre_pkg::*;

  // a held beat stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output beat dropped while stalled");

  // a held beat keeps its value, index and last flag
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable({m_axis_tdata, m_axis_tuser, m_axis_tlast}))
    else $error("output beat changed while stalled");

  // one element at a time: no accept in the cycle after an accept
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted in back-to-back cycles");

  // reset empties the output register
  a_reset_out: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid right after reset");

endmodule

bind matrix_vector_reduction_engine mvre_checker u_mvre_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

[bench/tb.sv]
// Self-checking bench for matrix_vector_reduction_engine: streams matrices in, checks every
// result beat against a cycle-free model of the sums, roots, RMS values and running sums.
// Depends on mvre_pkg and the RTL of the block.
`timescale 1ns / 1ps

class reduction_model;
  typedef struct {
    logic [mvre_pkg::VALUE_W-1:0] value;
    logic [mvre_pkg::INDEX_W-1:0] vec;
    logic                         last;
  } vec_result_t;

  localparam longint unsigned ACC_MASK = (64'd1 << mvre_pkg::ACC_W) - 1;

  vec_result_t      pending_results[$];
  mvre_pkg::mode_t  mode;
  bit               dir_rows;
  int unsigned      row_count, col_count;
  longint unsigned  col_acc[64];
  longint unsigned  row_acc;
  int unsigned      row_pos, col_pos;
  int               errors;
  int               results_seen;

  function new();
    mode = mvre_pkg::MODE_SUM;
    dir_rows = 0;
    row_count = 1;
    col_count = 1;
    errors = 0;
    results_seen = 0;
    restart();
  endfunction

  function void restart();
    foreach (col_acc[i]) col_acc[i] = 0;
    row_acc = 0;
    row_pos = 0;
    col_pos = 0;
  endfunction

  function void write_reg(logic [mvre_pkg::CFG_IDX_W-1:0] idx,
                          logic [mvre_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      mvre_pkg::CFG_MODE:      mode = mvre_pkg::mode_t'(data[1:0]);
      mvre_pkg::CFG_DIRECTION: dir_rows = data[0];
      mvre_pkg::CFG_ROW_COUNT: row_count = 32'(data[10:0]);
      mvre_pkg::CFG_COL_COUNT: col_count = 32'(data[6:0]);
      default: return;
    endcase
    restart();
  endfunction

  function longint unsigned floor_root(longint unsigned v);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 40;
    v &= ACC_MASK;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function longint unsigned finish_vec(longint unsigned acc, int unsigned len);
    if (mode == mvre_pkg::MODE_ROOT) return floor_root(acc);
    if (mode == mvre_pkg::MODE_RMS) return floor_root(acc / len);
    return acc;
  endfunction

  function void push(longint unsigned v, int unsigned idx, bit last);
    vec_result_t r;
    r.value = v[mvre_pkg::VALUE_W-1:0];
    r.vec = idx[mvre_pkg::INDEX_W-1:0];
    r.last = last;
    pending_results.push_back(r);
  endfunction

  function void take_element(logic [15:0] x);
    longint signed   sx;
    longint unsigned addend;
    int unsigned     rows, cols, c, r;
    bit              end_row, end_mat;
    sx = longint'($signed(x));
    rows = (row_count == 0) ? 1 : (row_count > 1024 ? 1024 : row_count);
    cols = (col_count == 0) ? 1 : (col_count > 64 ? 64 : col_count);
    if (mode == mvre_pkg::MODE_ROOT || mode == mvre_pkg::MODE_RMS)
      addend = longint'(sx * sx);
    else
      addend = sx;
    c = (col_pos >= cols) ? 0 : col_pos;
    r = (row_pos >= rows) ? 0 : row_pos;
    end_row = (c + 1 == cols);
    end_mat = end_row && (r + 1 == rows);
    if (!dir_rows) begin
      col_acc[c] = (col_acc[c] + addend) & ACC_MASK;
      if (mode == mvre_pkg::MODE_CUMSUM)
        push(col_acc[c], c, end_mat);
      else if (end_mat)
        for (int j = 0; j < cols; j++) push(finish_vec(col_acc[j], rows), j, j + 1 == cols);
      if (end_mat) foreach (col_acc[i]) col_acc[i] = 0;
    end else begin
      row_acc = (row_acc + addend) & ACC_MASK;
      if (mode == mvre_pkg::MODE_CUMSUM) push(row_acc, r, end_mat);
      else if (end_row) push(finish_vec(row_acc, cols), r, end_mat);
      if (end_row) row_acc = 0;
    end
    if (end_row) begin
      col_pos = 0;
      row_pos = end_mat ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
      row_pos = r;
    end
  endfunction

  function void match_result(logic [31:0] data, logic [mvre_pkg::INDEX_W-1:0] user, logic last);
    vec_result_t e;
    results_seen++;
    if (pending_results.size() == 0) begin
      $display("%0t: unexpected result beat value=%0h index=%0d last=%0b",
               $time, data, user, last);
      errors++;
      return;
    end
    e = pending_results.pop_front();
    if (data[mvre_pkg::VALUE_W-1:0] !== e.value) begin
      $display("%0t: value mismatch expected %0d actual %0d", $time,
               $signed(e.value), $signed(data[mvre_pkg::VALUE_W-1:0]));
      errors++;
    end
    if (user !== e.vec) begin
      $display("%0t: vector_index mismatch expected %0d actual %0d", $time, e.vec, user);
      errors++;
    end
    if (last !== e.last) begin
      $display("%0t: last mismatch expected %0b actual %0b", $time, e.last, last);
      errors++;
    end
  endfunction
endclass

module tb;
  import mvre_pkg::*;

  localparam int IDLE_LIMIT  = 20000;  // cycles with no beat on any channel
  localparam int HOLD_CYCLES = 2000;   // long receiver hold-off
  localparam int SETTLE      = 150;    // quiet cycles before a register write

  logic                  clk = 0;
  logic                  rst = 1;
  logic                  s_axis_tvalid = 0;
  logic                  s_axis_tready;
  logic [15:0]           s_axis_tdata = '0;   // element
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;        // value
  logic [INDEX_W-1:0]    m_axis_tuser;        // vector_index
  logic                  m_axis_tlast;
  logic                  cfg_valid = 0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  reduction_model model = new();

  bit no_gaps;        // stretch with back-to-back beats on both sides
  bit hold_request;   // ask the receiver for one long hold-off
  int items_sent;
  int phases;
  int idle_cycles = 0;

  matrix_vector_reduction_engine u_top (
    .clk, .rst,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // Check every output beat at the rising edge.
  always @(posedge clk)
    if (!rst && m_axis_tvalid && m_axis_tready)
      model.match_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);

  // Watchdog: end the run if no beat moves on any channel for too long.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: watchdog expired", $time);
      $display("tb NOT OK");
      $finish;
    end
  end

  // Receiver: random wait before each beat, or one long hold-off on request.
  initial begin
    int wait_cycles;
    bit held;
    held = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_request && !held) begin
        held = 1;
        m_axis_tready <= 0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      wait_cycles = no_gaps ? 0 : $urandom_range(0, 17);
      if (wait_cycles > 0) begin
        m_axis_tready <= 0;
        repeat (wait_cycles) @(negedge clk);
      end
      m_axis_tready <= 1;
      do @(posedge clk); while (!m_axis_tvalid);
      @(negedge clk);
    end
  end

  // Write one register; the block must be idle.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    model.write_reg(idx, data);
    @(negedge clk);
    cfg_valid <= 0;
    @(negedge clk);
  endtask

  // Offer one element; hold it until accepted.
  task automatic send_element(logic [15:0] x);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      s_axis_tvalid <= 0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata  <= x;
    do @(posedge clk); while (!s_axis_tready);
    model.take_element(x);
    items_sent++;
    @(negedge clk);
  endtask

  // Drop valid, then wait out every pending result plus a quiet stretch.
  task automatic drain();
    s_axis_tvalid <= 0;
    while (model.pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic configure(mode_t m, bit dir, int unsigned rows, int unsigned cols);
    drain();
    phases++;
    if ($urandom_range(0, 3) == 0)
      write_reg(CFG_IDX_W'($urandom_range(4, 15)), CFG_DATA_W'($urandom));
    if ($urandom_range(0, 1)) begin
      write_reg(CFG_ROW_COUNT, CFG_DATA_W'(rows));
      write_reg(CFG_COL_COUNT, CFG_DATA_W'(cols));
    end else begin
      write_reg(CFG_COL_COUNT, CFG_DATA_W'(cols));
      write_reg(CFG_ROW_COUNT, CFG_DATA_W'(rows));
    end
    write_reg(CFG_MODE, CFG_DATA_W'(m));
    write_reg(CFG_DIRECTION, CFG_DATA_W'(dir));
  endtask

  function automatic logic [15:0] pick_element();
    case ($urandom_range(0, 11))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    int unsigned rows, cols, count;
    mode_t       m;
    items_sent = 0;
    phases = 0;
    no_gaps = 0;
    hold_request = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // Directed: every mode in both directions with extreme elements.
    configure(MODE_SUM, 0, 2, 2);
    send_element(16'h7fff); send_element(16'h8000);
    send_element(16'hffff); send_element(16'h0000);
    configure(MODE_ROOT, 1, 1, 3);
    send_element(16'h8000); send_element(16'h7fff); send_element(16'h8000);
    configure(MODE_RMS, 0, 3, 2);
    repeat (6) send_element(16'h8000);
    configure(MODE_CUMSUM, 1, 2, 2);
    send_element(16'h7fff); send_element(16'h7fff);
    send_element(16'h8000); send_element(16'h0001);
    configure(MODE_CUMSUM, 0, 2, 2);
    repeat (4) send_element(16'h8000);
    // Counts of zero act as one; counts above the maximum act as the maximum.
    configure(MODE_SUM, 1, 0, 0);
    send_element(16'h8000); send_element(16'h1234);
    configure(MODE_ROOT, 0, 1, 127);
    repeat (64) send_element(16'h7fff);
    no_gaps = 1;
    configure(MODE_RMS, 1, 1024, 64);
    repeat (64) send_element(16'h8000);
    // Long receiver hold-off while elements keep coming: one result per
    // element, so the block fills up and stalls its input.
    configure(MODE_CUMSUM, 1, 4, 4);
    hold_request = 1;
    repeat (48) send_element(pick_element());
    no_gaps = 0;

    // Random phases: whole matrices with random content, some cut short.
    while (items_sent < 300) begin
      m = mode_t'($urandom_range(0, 3));
      if ($urandom_range(0, 9) == 0) begin
        rows = $urandom_range(1, 2);
        cols = 64;
      end else begin
        rows = $urandom_range(1, 6);
        cols = $urandom_range(1, 6);
      end
      no_gaps = ($urandom_range(0, 4) == 0);
      configure(m, 1'($urandom_range(0, 1)), rows, cols);
      count = rows * cols * $urandom_range(1, 3);
      if ($urandom_range(0, 4) == 0) count += $urandom_range(1, 3);
      repeat (count) send_element(pick_element());
    end

    drain();
    $display("Ran %0d elements over %0d register settings, %0d result beats checked.",
             items_sent, phases, model.results_seen);
    $display("Covered all four modes, both directions, count extremes and a long stall.");
    if (model.errors == 0 && model.pending_results.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("%0t: %0d errors, %0d results never arrived", $time,
               model.errors, model.pending_results.size());
      $display("tb NOT OK");
    end
    $finish;
  end
endmodule
